/* src/yuyv_to_planar_420_converter_core_defines.svh */
// assertion macros used by the converter back end
`ifndef YUYV_TO_PLANAR_420_CONVERTER_CORE_DEFINES_SVH
`define YUYV_TO_PLANAR_420_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define YTP_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("converter assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define YTP_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("converter assertion failed");

`endif

/* src/ytp_pkg.sv */
// types and constants shared by the yuyv to planar 4:2:0 converter
`timescale 1ns / 1ps
`default_nettype none

package ytp_pkg;

	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 13;
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;

	localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd480;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 4'd0,
		REG_FRAME_HEIGHT = 4'd1
	} ytp_reg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [7:0]  y0;
		logic [7:0]  u;
		logic [7:0]  y1;
		logic [7:0]  v;
		logic        odd;
		logic        last;
		logic [23:0] luma_idx;
		logic [21:0] chroma_idx;
	} ytp_item_t;

	// finished result word
	typedef struct packed {
		logic [7:0]  luma_left;
		logic [7:0]  luma_right;
		logic [23:0] luma_index;
		logic        chroma_valid;
		logic [7:0]  chroma_blue;
		logic [7:0]  chroma_red;
		logic [21:0] chroma_index;
		logic        frame_last;
	} ytp_result_t;

endpackage

`default_nettype wire

/* src/yuyv_to_planar_420_converter_core.sv */
// top level of the yuyv 4:2:2 to planar 4:2:0 converter
//
// Input channel: one YUYV macropixel word per push, accepted at a clock edge
// with push high and full low. Result channel: the oldest result word sits on
// the result ports while empty is low and is taken at an edge with pop high.
// Every input word gives exactly one result word, in order.
// Configuration: frame_width (index 0) and frame_height (index 1) are written
// over cfg_valid/cfg_ready, which is always ready; write only while idle.
// Path: an accepted word passes the front queue and the stage 1 register into
// the result queue that drives the result ports. Throughput: one word per cycle
// sustained while pop keeps the result queue from filling, set by the single-port
// access of the chroma line store per word (a write on even rows, a read on odd rows).
// Reset: arst_n clears the counters and both queues and restores 640x480;
// the line store is not cleared, since every odd row reads entries that the
// even row above has just written.
// Stall: when pop stays low the result queue fills, the back end stops taking
// words, the front queue fills and full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module yuyv_to_planar_420_converter_core #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ytp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ytp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [7:0]                      luma_first,
	input  wire logic [7:0]                      chroma_blue_in,
	input  wire logic [7:0]                      luma_second,
	input  wire logic [7:0]                      chroma_red_in,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [7:0]                           luma_left,
	output logic [7:0]                           luma_right,
	output logic [23:0]                          luma_index,
	output logic                                 chroma_valid,
	output logic [7:0]                           chroma_blue_out,
	output logic [7:0]                           chroma_red_out,
	output logic [21:0]                          chroma_index,
	output logic                                 frame_last
);

	import ytp_pkg::*;

	localparam int SLOT_W = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
	localparam int QW = SLOT_W + $bits(ytp_item_t);

	logic              q_push;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	ytp_item_t         f_item;
	logic [SLOT_W-1:0] f_slot;
	ytp_item_t         b_item;
	logic [SLOT_W-1:0] b_slot;
	logic [QW-1:0]     q_rdata;
	ytp_result_t       res;

	// front end
	ytp_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.luma_first(luma_first),
		.chroma_blue_in(chroma_blue_in),
		.luma_second(luma_second),
		.chroma_red_in(chroma_red_in),
		.q_push(q_push),
		.q_full(q_full),
		.q_item(f_item),
		.q_slot(f_slot)
	);

	// queue between front and back
	ytp_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata({f_slot, f_item}),
		.full(q_full),
		.pop(q_pop),
		.rdata(q_rdata),
		.empty(q_empty),
		.level()
	);

	assign b_slot = q_rdata[QW-1 -: SLOT_W];
	assign b_item = ytp_item_t'(q_rdata[$bits(ytp_item_t)-1:0]);

	// back end
	ytp_back #(
		.SLOT_W(SLOT_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.q_item(b_item),
		.q_slot(b_slot),
		.res(res),
		.empty(empty),
		.pop(pop)
	);

	// result ports
	assign luma_left       = res.luma_left;
	assign luma_right      = res.luma_right;
	assign luma_index      = res.luma_index;
	assign chroma_valid    = res.chroma_valid;
	assign chroma_blue_out = res.chroma_blue;
	assign chroma_red_out  = res.chroma_red;
	assign chroma_index    = res.chroma_index;
	assign frame_last      = res.frame_last;

endmodule

`default_nettype wire

/* src/ytp_fifo.sv */
// small register-based first-in first-out queue
`timescale 1ns / 1ps
`default_nettype none

module ytp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty,
	output logic      [PTR_W:0]   level
);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PTR_W + 1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign level   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// payload storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

/* src/ytp_front.sv */
// front end: configuration registers, raster counters and word classification
`timescale 1ns / 1ps
`default_nettype none

module ytp_front #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 4096,
	localparam int SLOT_W = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ytp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ytp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [7:0]                      luma_first,
	input  wire logic [7:0]                      chroma_blue_in,
	input  wire logic [7:0]                      luma_second,
	input  wire logic [7:0]                      chroma_red_in,
	output logic                                 q_push,
	input  wire logic                            q_full,
	output ytp_pkg::ytp_item_t                   q_item,
	output logic [SLOT_W-1:0]                    q_slot
);

	import ytp_pkg::*;

	localparam int STORE_DEPTH = MAX_WIDTH / 2;
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [SLOT_W-1:0]     col_q;
	logic [ROW_W-1:0]      row_q;
	logic [23:0]           luma_pos_q;
	logic [21:0]           chroma_pos_q;

	logic [13:0] pairs_raw;
	logic [13:0] pairs;
	logic [13:0] rows_raw;
	logic [13:0] rows;
	logic        line_end;
	logic        frame_end;
	logic        accept;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;
	assign q_push    = accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == REG_FRAME_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	// line and frame limits, odd sizes rounded down and clamped
	always_comb begin
		pairs_raw = {2'b00, width_q[12:1]};
		if (pairs_raw < 14'd1) begin
			pairs = 14'd1;
		end else if (pairs_raw > 14'(STORE_DEPTH)) begin
			pairs = 14'(STORE_DEPTH);
		end else begin
			pairs = pairs_raw;
		end
		rows_raw = {1'b0, height_q[12:1], 1'b0};
		if (rows_raw < 14'd2) begin
			rows = 14'd2;
		end else if (rows_raw > 14'(MAX_HEIGHT)) begin
			rows = 14'(MAX_HEIGHT);
		end else begin
			rows = rows_raw;
		end
		line_end  = 14'(col_q) >= (pairs - 14'd1);
		frame_end = line_end && (14'(row_q) >= (rows - 14'd1));
	end

	// classified word for the back end
	always_comb begin
		q_item.y0         = luma_first;
		q_item.u          = chroma_blue_in;
		q_item.y1         = luma_second;
		q_item.v          = chroma_red_in;
		q_item.odd        = row_q[0];
		q_item.last       = frame_end;
		q_item.luma_idx   = luma_pos_q;
		q_item.chroma_idx = row_q[0] ? chroma_pos_q : 22'd0;
		q_slot            = col_q;
	end

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			luma_pos_q   <= '0;
			chroma_pos_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q        <= '0;
				row_q        <= '0;
				luma_pos_q   <= '0;
				chroma_pos_q <= '0;
			end else begin
				luma_pos_q <= luma_pos_q + 24'd2;
				if (row_q[0]) begin
					chroma_pos_q <= chroma_pos_q + 22'd1;
				end
				if (line_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* src/ytp_back.sv */
// back end: chroma line store, vertical averaging and result queue
`timescale 1ns / 1ps
`default_nettype none
`include "yuyv_to_planar_420_converter_core_defines.svh"

module ytp_back #(
	parameter int SLOT_W = 11
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	output logic                     q_pop,
	input  wire ytp_pkg::ytp_item_t  q_item,
	input  wire logic [SLOT_W-1:0]   q_slot,
	output ytp_pkg::ytp_result_t     res,
	output logic                     empty,
	input  wire logic                pop
);

	import ytp_pkg::*;

	localparam int STORE_DEPTH = 2 ** SLOT_W;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

	logic [15:0]         line_mem [STORE_DEPTH];
	logic [15:0]         held_q;
	logic                valid_s1_q;
	ytp_item_t           item_s1;
	logic                issue;
	logic [OUT_PTR_W:0]  o_level;
	logic                o_full;
	ytp_result_t         res_d;
	logic [$bits(ytp_result_t)-1:0] o_rdata;
	logic [8:0]          sum_b;
	logic [8:0]          sum_r;

	// take a word only when the result queue has a free slot for it
	assign issue = !q_empty &&
		((OUT_PTR_W + 2)'(o_level) + (OUT_PTR_W + 2)'(valid_s1_q) < (OUT_PTR_W + 2)'(OUT_DEPTH));
	assign q_pop = issue;

	// line store: even rows write, odd rows read the row above
	always_ff @(posedge clk) begin
		if (issue && !q_item.odd) begin
			line_mem[q_slot] <= {q_item.v, q_item.u};
		end
		if (issue && q_item.odd) begin
			held_q <= line_mem[q_slot];
		end
	end

	// stage 1 valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else begin
			valid_s1_q <= issue;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (issue) begin
			item_s1 <= q_item;
		end
	end

	// rounded average of the two rows
	always_comb begin
		sum_b = {1'b0, held_q[7:0]} + {1'b0, item_s1.u} + 9'd1;
		sum_r = {1'b0, held_q[15:8]} + {1'b0, item_s1.v} + 9'd1;
		res_d.luma_left    = item_s1.y0;
		res_d.luma_right   = item_s1.y1;
		res_d.luma_index   = item_s1.luma_idx;
		res_d.chroma_valid = item_s1.odd;
		res_d.chroma_blue  = item_s1.odd ? sum_b[8:1] : 8'd0;
		res_d.chroma_red   = item_s1.odd ? sum_r[8:1] : 8'd0;
		res_d.chroma_index = item_s1.chroma_idx;
		res_d.frame_last   = item_s1.last;
	end

	// result queue toward the receiver
	ytp_fifo #(
		.WIDTH($bits(ytp_result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(valid_s1_q),
		.wdata(res_d),
		.full(o_full),
		.pop(pop),
		.rdata(o_rdata),
		.empty(empty),
		.level(o_level)
	);

	assign res = ytp_result_t'(o_rdata);

	// checks
	`YTP_ASSERT_IMP(a_no_overflow, valid_s1_q, !o_full)
	`YTP_ASSERT_NEXT(a_issue_reaches_s1, issue, valid_s1_q)
	`YTP_ASSERT_IMP(a_chroma_on_odd, valid_s1_q, res_d.chroma_valid == item_s1.odd && (item_s1.odd || res_d.chroma_blue == 8'd0))

endmodule

`default_nettype wire
